// ----- sv/tuple_segment_parser_assert.svh -----
// Assertion helpers for the checker file of the tuple segment parser.
// TSP_ASSERT expects signals clk and arst_n in scope; TSP_ASSERT_ALWAYS only clk.
`ifndef TUPLE_SEGMENT_PARSER_ASSERT_SVH
`define TUPLE_SEGMENT_PARSER_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define TSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define TSP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/tsp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants of the tuple segment parser
// Result kind codes, tag bytes, configuration register indexes and the
// result record that travels from the parser logic to the output stage.
// ----------------------------------------------------------------------------
package tsp_pkg;

	localparam int NAME_CHARS = 8;
	localparam int CFG_INDEX_W = 2;

	localparam logic [7:0] TAG_INT    = 8'd1;
	localparam logic [7:0] TAG_FLOAT  = 8'd3;
	localparam logic [7:0] TAG_STRING = 8'd5;
	localparam logic [7:0] TAG_END    = 8'd23;

	localparam logic [CFG_INDEX_W-1:0] REG_NAME_BYTES  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NAME_LENGTH = 2'd1;

	typedef enum logic [2:0] {
		KIND_INT      = 3'd0,
		KIND_FLOAT    = 3'd1,
		KIND_STR_BYTE = 3'd2,
		KIND_END      = 3'd3,
		KIND_MISMATCH = 3'd4,
		KIND_BAD_TAG  = 3'd5,
		KIND_OVERFLOW = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  field_number;
		logic [31:0] word_value;
		logic        string_last;
		logic [10:0] total_length;
	} result_t;

endpackage
`default_nettype wire

// ----- sv/tuple_segment_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tuple_segment_parser: byte-stream parser for tagged tuple segments
// Checks the configured name, then decodes int, float, string and end tags
// and reports one result per data word, string byte, end or error.
// ----------------------------------------------------------------------------
// The parser takes one byte in every cycle while in_ready is high. The byte
// is decoded in the cycle it is accepted and its result, if any, goes into
// the output register, or into the skid entry behind it while the output
// register holds a result not yet taken. in_ready stays high while a single
// result waits; it drops only while both entries hold results, and returns
// once the consumer takes one. State needs no clearing pass after reset.
module tuple_segment_parser #(
	parameter int MAX_FIELDS    = 16,
	parameter int SEGMENT_BYTES = 1024
) (
	input  wire                                 clk,
	input  wire                                 arst_n,

	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [tsp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire  [63:0]                         cfg_data,

	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [7:0]                          data_byte,
	input  wire                                 segment_start,

	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [2:0]                          kind,
	output logic [3:0]                          field_number,
	output logic [31:0]                         word_value,
	output logic                                string_last,
	output logic [10:0]                         total_length
);

	localparam int PW = $clog2(SEGMENT_BYTES + 1);
	localparam int FW = $clog2(MAX_FIELDS + 1);
	localparam logic [PW-1:0] SEG_LIMIT = PW'(SEGMENT_BYTES);
	localparam logic [FW-1:0] FIELD_LIMIT = FW'(MAX_FIELDS);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_NAME,
		PH_TAG,
		PH_NUM,
		PH_STR
	} phase_t;

	// Configuration registers
	logic [63:0] name_bytes_q;
	logic [3:0]  name_length_q;

	// Parser state
	phase_t       phase_q, phase_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [1:0]   cnt_q, cnt_d;
	logic [23:0]  acc_q, acc_d;
	logic [FW-1:0] fc_q, fc_d;
	logic         isf_q, isf_d;

	// Working copies after a segment start has been applied
	phase_t        ph;
	logic [PW-1:0] pos;
	logic [PW-1:0] pos_inc;
	logic [1:0]    cnt;
	logic [23:0]   acc;
	logic [FW-1:0] fc;
	logic          isf;
	logic [3:0]    nlen;
	logic [7:0]    want;
	logic [FW+3:0] fc_ext;
	logic [PW+10:0] tl_ext;

	logic              accept;
	logic              emit;
	tsp_pkg::result_t  res;

	// Output stage
	logic              out_valid_q;
	logic              skid_valid_q;
	tsp_pkg::result_t  out_q;
	tsp_pkg::result_t  skid_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !skid_valid_q;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_bytes_q  <= '0;
			name_length_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == tsp_pkg::REG_NAME_BYTES) begin
				name_bytes_q <= cfg_data;
			end else if (cfg_index == tsp_pkg::REG_NAME_LENGTH) begin
				name_length_q <= cfg_data[3:0];
			end
		end
	end

	always_comb begin
		nlen = (name_length_q > 4'(tsp_pkg::NAME_CHARS)) ? 4'(tsp_pkg::NAME_CHARS)
			: name_length_q;
		// A segment start clears the partial parse before this byte is decoded.
		ph  = segment_start ? PH_NAME : phase_q;
		pos = segment_start ? '0 : pos_q;
		cnt = segment_start ? '0 : cnt_q;
		acc = segment_start ? '0 : acc_q;
		fc  = segment_start ? '0 : fc_q;
		isf = segment_start ? 1'b0 : isf_q;
		pos_inc = pos + 1'b1;
		want    = name_bytes_q[{pos[2:0], 3'b000} +: 8];
		fc_ext  = {4'b0000, fc};
		tl_ext  = {11'b0, pos_inc};

		phase_d = ph;
		pos_d   = pos;
		cnt_d   = cnt;
		acc_d   = acc;
		fc_d    = fc;
		isf_d   = isf;

		emit              = 1'b0;
		res.kind          = tsp_pkg::KIND_OVERFLOW;
		res.field_number  = '0;
		res.word_value    = '0;
		res.string_last   = 1'b0;
		res.total_length  = '0;

		if (ph == PH_IDLE) begin
			emit = 1'b0;
		end else if (pos >= SEG_LIMIT) begin
			emit     = 1'b1;
			res.kind = tsp_pkg::KIND_OVERFLOW;
			phase_d  = PH_IDLE;
		end else begin
			pos_d = pos_inc;
			unique case (ph)
				PH_NAME: begin
					if (pos < PW'(nlen)) begin
						if (data_byte != want) begin
							emit     = 1'b1;
							res.kind = tsp_pkg::KIND_MISMATCH;
							phase_d  = PH_IDLE;
						end
					end else begin
						phase_d = PH_TAG;
					end
				end
				PH_TAG: begin
					if (data_byte == tsp_pkg::TAG_END) begin
						emit             = 1'b1;
						res.kind         = tsp_pkg::KIND_END;
						res.total_length = tl_ext[10:0];
						phase_d          = PH_IDLE;
					end else if (data_byte == tsp_pkg::TAG_INT ||
							data_byte == tsp_pkg::TAG_FLOAT ||
							data_byte == tsp_pkg::TAG_STRING) begin
						if (fc >= FIELD_LIMIT) begin
							emit     = 1'b1;
							res.kind = tsp_pkg::KIND_OVERFLOW;
							phase_d  = PH_IDLE;
						end else if (data_byte == tsp_pkg::TAG_STRING) begin
							phase_d = PH_STR;
						end else begin
							phase_d = PH_NUM;
							isf_d   = (data_byte == tsp_pkg::TAG_FLOAT);
							cnt_d   = '0;
							acc_d   = '0;
						end
					end else begin
						emit           = 1'b1;
						res.kind       = tsp_pkg::KIND_BAD_TAG;
						res.word_value = {24'b0, data_byte};
						phase_d        = PH_IDLE;
					end
				end
				PH_NUM: begin
					if (cnt != 2'd3) begin
						acc_d = {acc[15:0], data_byte};
						cnt_d = cnt + 2'd1;
					end else begin
						emit             = 1'b1;
						res.kind         = isf ? tsp_pkg::KIND_FLOAT : tsp_pkg::KIND_INT;
						res.field_number = fc_ext[3:0];
						res.word_value   = {acc, data_byte};
						cnt_d            = '0;
						acc_d            = '0;
						fc_d             = fc + 1'b1;
						phase_d          = PH_TAG;
					end
				end
				PH_STR: begin
					emit             = 1'b1;
					res.kind         = tsp_pkg::KIND_STR_BYTE;
					res.field_number = fc_ext[3:0];
					res.word_value   = {24'b0, data_byte};
					res.string_last  = (data_byte == 8'd0);
					if (data_byte == 8'd0) begin
						fc_d    = fc + 1'b1;
						phase_d = PH_TAG;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			cnt_q   <= '0;
			acc_q   <= '0;
			fc_q    <= '0;
			isf_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			cnt_q   <= cnt_d;
			acc_q   <= acc_d;
			fc_q    <= fc_d;
			isf_q   <= isf_d;
		end
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept && emit) begin
			if (out_valid_q && !out_ready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_q <= skid_q;
			end
		end else if (accept && emit) begin
			if (out_valid_q && !out_ready) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_q.kind;
	assign field_number = out_q.field_number;
	assign word_value   = out_q.word_value;
	assign string_last  = out_q.string_last;
	assign total_length = out_q.total_length;

endmodule
`default_nettype wire

// ----- sv/tsp_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_checker: port-level assertions for the tuple segment parser
// Watches the result channel for held requests and consistent result fields, and cfg_ready for stalls.
// ----------------------------------------------------------------------------
`include "tuple_segment_parser_assert.svh"

module tsp_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        cfg_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [2:0]  kind,
	input wire [3:0]  field_number,
	input wire [31:0] word_value,
	input wire        string_last,
	input wire [10:0] total_length
);

	// A stalled result request must hold its payload.
	`TSP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(field_number) && $stable(word_value) && $stable(string_last) && $stable(total_length), "result changed while stalled")

	// An end result carries only the length, and the end marker counts.
	`TSP_ASSERT(a_end_fields, out_valid && kind == tsp_pkg::KIND_END |-> field_number == 4'd0 && word_value == 32'd0 && !string_last && total_length != 11'd0, "bad end result")

	// A string byte flags the terminator exactly when the byte is zero.
	`TSP_ASSERT(a_str_fields, out_valid && kind == tsp_pkg::KIND_STR_BYTE |-> string_last == (word_value[7:0] == 8'd0) && word_value[31:8] == 24'd0 && total_length == 11'd0, "bad string result")

	// Numeric words never carry string or length fields.
	`TSP_ASSERT(a_num_fields, out_valid && (kind == tsp_pkg::KIND_INT || kind == tsp_pkg::KIND_FLOAT) |-> !string_last && total_length == 11'd0, "bad numeric result")

	// The configuration port never stalls.
	`TSP_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration port stalled")

endmodule

bind tuple_segment_parser tsp_checker u_tsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_ready    (cfg_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.kind         (kind),
	.field_number (field_number),
	.word_value   (word_value),
	.string_last  (string_last),
	.total_length (total_length)
);
`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the tuple segment parser
// A short table of hand-written requests runs first, then random segments
// under several name settings. Every accepted byte is run through a local
// parser model, and each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
	import tsp_pkg::*;

	localparam int MAX_FIELDS    = 16;
	localparam int SEGMENT_BYTES = 1024;
	localparam int TAIL_CYCLES   = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 3000;
	localparam int RANDOM_BYTES  = 840;
	localparam int NUM_SETTINGS  = 6;

	typedef enum int {PH_IDLE, PH_NAME, PH_TAG, PH_NUM, PH_STR} parse_phase_t;

	typedef struct {
		bit          start;
		logic [7:0]  data;
		bit          fixed;
		result_t     want;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [63:0]            cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [7:0]             data_byte = '0;
	logic                   segment_start = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [2:0]             kind;
	logic [3:0]             field_number;
	logic [31:0]            word_value;
	logic                   string_last;
	logic [10:0]            total_length;

	// Local copy of the parser state and its name registers.
	logic [63:0]  exp_name = '0;
	logic [3:0]   exp_name_len = '0;
	parse_phase_t ps = PH_IDLE;
	int           byte_pos = 0;
	int           num_cnt = 0;
	int           field_cnt = 0;
	logic [23:0]  acc = '0;
	bit           is_float = 1'b0;

	result_t      pending_results[$];
	bit           seg_s[$];
	logic [7:0]   seg_b[$];
	stim_row_t    dir_rows[$];

	int n_sent = 0;
	int n_used = 0;
	int n_results = 0;
	int n_errors = 0;
	int n_cfg_writes = 0;
	int n_holds = 0;
	int stall_cycles = 0;
	bit hold_req = 1'b0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	tuple_segment_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.segment_start (segment_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.field_number  (field_number),
		.word_value    (word_value),
		.string_last   (string_last),
		.total_length  (total_length)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void parse_byte(input bit s, input logic [7:0] b, output bit used,
			output bit hit, output result_t r);
		int nlen;
		int pos;
		nlen = (exp_name_len > NAME_CHARS) ? NAME_CHARS : int'(exp_name_len);
		used = 1'b0;
		hit = 1'b0;
		r = '0;
		if (s) begin
			ps = PH_NAME;
			byte_pos = 0;
			num_cnt = 0;
			acc = '0;
			field_cnt = 0;
			is_float = 1'b0;
		end
		if (ps == PH_IDLE)
			return;
		used = 1'b1;
		if (byte_pos >= SEGMENT_BYTES) begin
			ps = PH_IDLE;
			hit = 1'b1;
			r.kind = KIND_OVERFLOW;
			return;
		end
		pos = byte_pos;
		byte_pos = pos + 1;
		case (ps)
			PH_NAME: begin
				if (pos < nlen) begin
					if (b != exp_name[8*pos +: 8]) begin
						ps = PH_IDLE;
						hit = 1'b1;
						r.kind = KIND_MISMATCH;
					end
				end else begin
					ps = PH_TAG;
				end
			end
			PH_TAG: begin
				if (b == TAG_END) begin
					ps = PH_IDLE;
					hit = 1'b1;
					r.kind = KIND_END;
					r.total_length = 11'(pos + 1);
				end else if (b == TAG_INT || b == TAG_FLOAT || b == TAG_STRING) begin
					if (field_cnt >= MAX_FIELDS) begin
						ps = PH_IDLE;
						hit = 1'b1;
						r.kind = KIND_OVERFLOW;
					end else if (b == TAG_STRING) begin
						ps = PH_STR;
					end else begin
						ps = PH_NUM;
						is_float = (b == TAG_FLOAT);
						num_cnt = 0;
						acc = '0;
					end
				end else begin
					ps = PH_IDLE;
					hit = 1'b1;
					r.kind = KIND_BAD_TAG;
					r.word_value = {24'd0, b};
				end
			end
			PH_NUM: begin
				if (num_cnt < 3) begin
					acc = {acc[15:0], b};
					num_cnt++;
				end else begin
					hit = 1'b1;
					r.kind = is_float ? KIND_FLOAT : KIND_INT;
					r.field_number = 4'(field_cnt);
					r.word_value = {acc, b};
					num_cnt = 0;
					acc = '0;
					field_cnt++;
					ps = PH_TAG;
				end
			end
			PH_STR: begin
				hit = 1'b1;
				r.kind = KIND_STR_BYTE;
				r.field_number = 4'(field_cnt);
				r.word_value = {24'd0, b};
				r.string_last = (b == 8'd0);
				if (b == 8'd0) begin
					field_cnt++;
					ps = PH_TAG;
				end
			end
			default: ps = PH_IDLE;
		endcase
	endfunction

	function automatic result_t res(input kind_t k, input int f, input logic [31:0] w,
			input bit last, input int total);
		result_t r;
		r.kind = k;
		r.field_number = 4'(f);
		r.word_value = w;
		r.string_last = last;
		r.total_length = 11'(total);
		return r;
	endfunction

	function automatic void add_row(input bit s, input logic [7:0] b, input bit fixed = 1'b0,
			input result_t want = '0);
		stim_row_t row;
		row.start = s;
		row.data = b;
		row.fixed = fixed;
		row.want = want;
		dir_rows.push_back(row);
	endfunction

	function automatic void put(input bit s, input logic [7:0] b);
		seg_s.push_back(s);
		seg_b.push_back(b);
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
			n_errors++;
		end
	endfunction

	// One request on the byte channel. A fixed expectation replaces the model's
	// result, but the model still steps so that its state stays in line.
	task automatic send_byte(input bit s, input logic [7:0] b, input bit fixed,
			input result_t want);
		int gap;
		bit used;
		bit hit;
		result_t r;
		gap = tx_steady ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		segment_start <= s;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		parse_byte(s, b, used, hit, r);
		n_sent++;
		if (used)
			n_used++;
		if (fixed)
			pending_results.push_back(want);
		else if (hit)
			pending_results.push_back(r);
	endtask

	task automatic send_segment();
		for (int i = 0; i < seg_b.size(); i++)
			send_byte(seg_s[i], seg_b[i], 1'b0, '0);
		seg_s.delete();
		seg_b.delete();
	endtask

	// Name registers change only once the parser has drained.
	task automatic set_name(input logic [63:0] chars, input logic [3:0] len);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_NAME_BYTES;
		cfg_data <= chars;
		do @(posedge clk); while (!cfg_ready);
		exp_name = chars;
		cfg_index <= REG_NAME_LENGTH;
		cfg_data <= {60'd0, len};
		do @(posedge clk); while (!cfg_ready);
		exp_name_len = len;
		cfg_valid <= 1'b0;
		n_cfg_writes += 2;
	endtask

	function automatic void build_random_segment();
		int sel;
		int nlen;
		int nfields;
		int cut;
		int tag_at[$];
		logic [7:0] t;
		nlen = (exp_name_len > NAME_CHARS) ? NAME_CHARS : int'(exp_name_len);
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			repeat ($urandom_range(1, 12)) put($urandom_range(0, 7) == 0, 8'($urandom));
			return;
		end
		for (int i = 0; i < nlen; i++)
			put(i == 0, exp_name[8*i +: 8]);
		put(nlen == 0, 8'($urandom));
		case ($urandom_range(0, 15))
			0: nfields = MAX_FIELDS;
			1: nfields = MAX_FIELDS + 1;
			default: nfields = $urandom_range(0, 6);
		endcase
		for (int f = 0; f < nfields; f++) begin
			tag_at.push_back(seg_b.size());
			if ($urandom_range(0, 2) == 0) begin
				put(1'b0, TAG_STRING);
				repeat ($urandom_range(0, 5)) put(1'b0, 8'($urandom_range(1, 255)));
				put(1'b0, 8'd0);
			end else begin
				put(1'b0, $urandom_range(0, 1) ? TAG_INT : TAG_FLOAT);
				// Word bytes lean toward all zeros and all ones now and then.
				repeat (4) put(1'b0, ($urandom_range(0, 3) == 0) ?
					($urandom_range(0, 1) ? 8'hFF : 8'h00) : 8'($urandom));
			end
		end
		tag_at.push_back(seg_b.size());
		put(1'b0, TAG_END);
		if (sel < 85)
			return;
		sel = $urandom_range(0, 2);
		if (sel == 0 && nlen > 0) begin
			cut = $urandom_range(0, nlen - 1);
			seg_b[cut] = seg_b[cut] ^ 8'($urandom_range(1, 255));
		end else if (sel == 2) begin
			// Cut short; the next segment start has to discard the partial parse.
			cut = $urandom_range(1, seg_b.size() - 1);
			while (seg_b.size() > cut) begin
				seg_b.pop_back();
				seg_s.pop_back();
			end
		end else begin
			do t = 8'($urandom); while (t == TAG_INT || t == TAG_FLOAT ||
				t == TAG_STRING || t == TAG_END);
			seg_b[tag_at[$urandom_range(0, tag_at.size() - 1)]] = t;
		end
	endfunction

	// Result monitor.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, got kind %0d word 0x%0h",
					$time, kind, word_value);
				n_errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(kind));
				check_field("field_number", 32'(want.field_number), 32'(field_number));
				check_field("word_value", want.word_value, word_value);
				check_field("string_last", 32'(want.string_last), 32'(string_last));
				check_field("total_length", 32'(want.total_length), 32'(total_length));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	// Result consumer.
	initial begin
		int gap;
		int served;
		served = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				n_holds++;
			end
			if (served % 40 == 0)
				rx_steady = ($urandom_range(0, 3) == 0);
			gap = rx_steady ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			served++;
		end
	end

	initial begin
		int goal;
		int nlen;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Name "ab": one well-formed tuple, then the error paths.
		add_row(1'b0, 8'hA5);
		add_row(1'b1, 8'h61);
		add_row(1'b0, 8'h62);
		add_row(1'b0, 8'h00);
		add_row(1'b0, TAG_INT);
		repeat (3) add_row(1'b0, 8'hFF);
		add_row(1'b0, 8'hFF, 1'b1, res(KIND_INT, 0, 32'hFFFF_FFFF, 1'b0, 0));
		add_row(1'b0, TAG_FLOAT);
		repeat (3) add_row(1'b0, 8'h00);
		add_row(1'b0, 8'h00, 1'b1, res(KIND_FLOAT, 1, 32'h0, 1'b0, 0));
		add_row(1'b0, TAG_STRING);
		add_row(1'b0, 8'h7E);
		add_row(1'b0, 8'h00, 1'b1, res(KIND_STR_BYTE, 2, 32'h0, 1'b1, 0));
		add_row(1'b0, TAG_END, 1'b1, res(KIND_END, 0, 32'h0, 1'b0, 17));
		add_row(1'b1, 8'h78, 1'b1, res(KIND_MISMATCH, 0, 32'h0, 1'b0, 0));
		add_row(1'b1, 8'h61);
		add_row(1'b1, 8'h61);
		add_row(1'b0, 8'h62);
		add_row(1'b0, 8'h55);
		add_row(1'b0, 8'hFF, 1'b1, res(KIND_BAD_TAG, 0, 32'hFF, 1'b0, 0));
		add_row(1'b0, TAG_INT);

		set_name(64'h6261, 4'd2);
		foreach (dir_rows[i])
			send_byte(dir_rows[i].start, dir_rows[i].data, dir_rows[i].fixed, dir_rows[i].want);

		for (int p = 0; p < NUM_SETTINGS; p++) begin
			case (p)
				0: set_name('1, 4'd0);
				1: set_name({$urandom, $urandom}, 4'd8);
				2: set_name('0, 4'd15);
				4: set_name('1, 4'd8);
				default: set_name({$urandom, $urandom}, 4'($urandom_range(1, 15)));
			endcase
			nlen = (exp_name_len > NAME_CHARS) ? NAME_CHARS : int'(exp_name_len);
			if (p == 0) begin
				// Long string while the consumer stalls, so the parser backs up.
				hold_req = 1'b1;
				put(1'b1, 8'($urandom));
				put(1'b0, TAG_STRING);
				repeat (40) put(1'b0, 8'($urandom_range(1, 255)));
				put(1'b0, 8'd0);
				put(1'b0, TAG_END);
				send_segment();
			end
			if (p == 3) begin
				// Fill the whole buffer with one string; the next byte overflows.
				for (int i = 0; i < nlen; i++)
					put(i == 0, exp_name[8*i +: 8]);
				put(nlen == 0, 8'($urandom));
				put(1'b0, TAG_STRING);
				while (seg_b.size() < SEGMENT_BYTES)
					put(1'b0, 8'($urandom_range(1, 255)));
				put(1'b0, 8'($urandom));
				send_segment();
			end
			goal = n_sent + RANDOM_BYTES / NUM_SETTINGS;
			while (n_sent < goal) begin
				if ($urandom_range(0, 20) == 0)
					tx_steady = ($urandom_range(0, 2) == 0);
				build_random_segment();
				send_segment();
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d bytes (%0d parsed, rest ignored while idle), checked %0d results.",
			n_sent, n_used, n_results);
		$display("Wrote %0d registers over %0d name settings, %0d long consumer stalls.",
			n_cfg_writes, NUM_SETTINGS + 1, n_holds);
		if (n_errors == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
